>>> design/tidtt_pkg.sv
// Package for the transaction-ID translation table.
// Holds the entry record, scan status flags, status and kind codes.
// No dependencies.
`default_nettype none

package tidtt_pkg;

    // Default number of table entries
    localparam int DEFAULT_DEPTH = 64;

    // Field widths fixed by the interface
    localparam int ID_W    = 16;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int STAT_W  = 2;
    localparam int USED_W  = 7;

    // Item kinds
    localparam logic KIND_FORWARD = 1'b0;
    localparam logic KIND_RETURN  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    // One table entry
    typedef struct packed {
        logic [ID_W-1:0]   out_id;
        logic [ID_W-1:0]   orig_id;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } entry_t;

    // Flags gathered over one scan of the table
    typedef struct packed {
        logic found;    // an entry carries the key as outgoing ID
        logic ins_set;  // an entry with outgoing ID above the key was seen
        logic gap_set;  // an entry whose outgoing ID differs from its index was seen
    } scan_flags_t;

endpackage : tidtt_pkg

`default_nettype wire

>>> design/txn_id_translation_table.sv
// Transaction-ID translation table, sorted by outgoing ID, one item at a time.
// Each item scans the N live entries one a cycle; an empty table, or a full one on an insert,
// skips the scan. Then S entries move through the entry RAM, each by a read and then a write,
// and an insert writes its new entry. One item at a time: input stalls while an item is in work.
// Reset: asynchronous, active low; clears the entry count, the sequencer and out_valid, entries stay.
`default_nettype none

module txn_id_translation_table #(
    parameter int TABLE_DEPTH = tidtt_pkg::DEFAULT_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         kind,
    input  wire logic [tidtt_pkg::ID_W-1:0]   txn_id,
    input  wire logic [tidtt_pkg::ADDR_W-1:0] client_addr,
    input  wire logic [tidtt_pkg::PORT_W-1:0] client_port,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [tidtt_pkg::ID_W-1:0]        out_id,
    output logic [tidtt_pkg::ADDR_W-1:0]      reply_addr,
    output logic [tidtt_pkg::PORT_W-1:0]      reply_port,
    output logic [tidtt_pkg::STAT_W-1:0]      status,
    output logic [tidtt_pkg::USED_W-1:0]      used_count
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_DRAIN    = 3'd2;
    localparam logic [2:0] S_DECIDE   = 3'd3;
    localparam logic [2:0] S_SHIFT_RD = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;
    localparam logic [2:0] S_WRITE    = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [2:0]                        state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [CW-1:0]                     scan_idx_reg, scan_idx_next;
    logic                              cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]                     cmp_idx_reg;
    logic [CW-1:0]                     ptr_reg, ptr_next;
    logic [CW-1:0]                     pos_reg, pos_next;
    logic                              kind_reg;
    logic [tidtt_pkg::ID_W-1:0]        id_reg;
    logic [tidtt_pkg::ADDR_W-1:0]      addr_reg;
    logic [tidtt_pkg::PORT_W-1:0]      port_reg;
    logic [tidtt_pkg::ID_W-1:0]        new_id_reg, new_id_next;
    logic [tidtt_pkg::ID_W-1:0]        res_id_reg, res_id_next;
    logic [tidtt_pkg::ADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic [tidtt_pkg::PORT_W-1:0]      res_port_reg, res_port_next;
    logic [tidtt_pkg::STAT_W-1:0]      res_stat_reg, res_stat_next;
    logic                              out_valid_reg, out_valid_next;
    logic [tidtt_pkg::ID_W-1:0]        out_id_reg;
    logic [tidtt_pkg::ADDR_W-1:0]      out_addr_reg;
    logic [tidtt_pkg::PORT_W-1:0]      out_port_reg;
    logic [tidtt_pkg::STAT_W-1:0]      out_stat_reg;
    logic [tidtt_pkg::USED_W-1:0]      out_used_reg;

    logic                              in_xfer;
    logic                              out_free;
    logic                              scan_clear;
    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    tidtt_pkg::entry_t                 ram_wdata;
    logic [AW-1:0]                     ram_raddr;
    tidtt_pkg::entry_t                 ram_rdata;
    tidtt_pkg::scan_flags_t            scan_flags;
    logic [CW-1:0]                     found_pos;
    logic [CW-1:0]                     ins_pos;
    logic [CW-1:0]                     gap_pos;
    tidtt_pkg::entry_t                 hit_entry;
    logic [CW-1:0]                     ins_eff;
    logic [CW-1:0]                     gap_eff;
    logic [CW-1:0]                     shift_src;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_xfer    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign scan_clear = in_xfer;

    // Positions default to the table end when no entry set them
    assign ins_eff = scan_flags.ins_set ? ins_pos : count_reg;
    assign gap_eff = scan_flags.gap_set ? gap_pos : count_reg;

    // Source of a move: below on insert, above on removal
    assign shift_src = (kind_reg == tidtt_pkg::KIND_FORWARD) ? (ptr_reg - ONE_C)
                                                             : (ptr_reg + ONE_C);

    // Entry RAM access
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = (state_reg == S_SCAN) ? scan_idx_reg[AW-1:0] : shift_src[AW-1:0];
        if (state_reg == S_SHIFT_WR)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_WRITE)
        begin
            ram_we            = 1'b1;
            ram_waddr         = pos_reg[AW-1:0];
            ram_wdata.out_id  = new_id_reg;
            ram_wdata.orig_id = id_reg;
            ram_wdata.addr    = addr_reg;
            ram_wdata.port    = port_reg;
        end
    end

    tidtt_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tidtt_scan_unit #(
        .CW (CW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (scan_clear),
        .cmp_valid (cmp_valid_reg),
        .cmp_idx   (cmp_idx_reg),
        .entry     (ram_rdata),
        .key       (id_reg),
        .flags     (scan_flags),
        .found_pos (found_pos),
        .ins_pos   (ins_pos),
        .gap_pos   (gap_pos),
        .hit_entry (hit_entry)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = (state_reg == S_SCAN);
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        new_id_next    = new_id_reg;
        res_id_next    = res_id_reg;
        res_addr_next  = res_addr_reg;
        res_port_next  = res_port_reg;
        res_stat_next  = res_stat_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    scan_idx_next = '0;
                    res_id_next   = '0;
                    res_addr_next = '0;
                    res_port_next = '0;
                    res_stat_next = tidtt_pkg::ST_OK;
                    if (kind == tidtt_pkg::KIND_FORWARD && count_reg >= DEPTH_C)
                    begin
                        res_stat_next = tidtt_pkg::ST_FULL;
                        state_next    = S_FINISH;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Issue one read a cycle
                scan_idx_next = scan_idx_reg + ONE_C;
                if (scan_idx_reg == count_reg - ONE_C)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (kind_reg == tidtt_pkg::KIND_FORWARD)
                begin
                    if (scan_flags.found)
                    begin
                        pos_next    = gap_eff;
                        new_id_next = tidtt_pkg::ID_W'(gap_eff);
                    end
                    else
                    begin
                        pos_next    = ins_eff;
                        new_id_next = id_reg;
                    end
                    ptr_next = count_reg;
                    if ((scan_flags.found ? gap_eff : ins_eff) == count_reg)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
                else if (scan_flags.found)
                begin
                    res_id_next   = hit_entry.orig_id;
                    res_addr_next = hit_entry.addr;
                    res_port_next = hit_entry.port;
                    count_next    = count_reg - ONE_C;
                    ptr_next      = found_pos;
                    if (found_pos == count_reg - ONE_C)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
                else
                begin
                    res_stat_next = tidtt_pkg::ST_NOT_FOUND;
                    state_next    = S_FINISH;
                end
            end
            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                // Advance the move pointer
                if (kind_reg == tidtt_pkg::KIND_FORWARD)
                begin
                    ptr_next = ptr_reg - ONE_C;
                    if (ptr_reg - ONE_C == pos_reg)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + ONE_C;
                    if (ptr_reg + ONE_C == count_reg)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
            end
            S_WRITE:
            begin
                count_next  = count_reg + ONE_C;
                res_id_next = new_id_reg;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: drop on transfer, raise when a result is handed over
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_FINISH && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Work registers
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= scan_idx_reg;
        ptr_reg      <= ptr_next;
        pos_reg      <= pos_next;
        new_id_reg   <= new_id_next;
        res_id_reg   <= res_id_next;
        res_addr_reg <= res_addr_next;
        res_port_reg <= res_port_next;
        res_stat_reg <= res_stat_next;
        if (in_xfer)
        begin
            kind_reg <= kind;
            id_reg   <= txn_id;
            addr_reg <= client_addr;
            port_reg <= client_port;
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINISH && out_free)
        begin
            out_id_reg   <= res_id_reg;
            out_addr_reg <= res_addr_reg;
            out_port_reg <= res_port_reg;
            out_stat_reg <= res_stat_reg;
            out_used_reg <= tidtt_pkg::USED_W'(count_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_id     = out_id_reg;
    assign reply_addr = out_addr_reg;
    assign reply_port = out_port_reg;
    assign status     = out_stat_reg;
    assign used_count = out_used_reg;

endmodule : txn_id_translation_table

`default_nettype wire

>>> design/tidtt_entry_ram.sv
// Entry store of the translation table: one write port, one read port.
// Read data is registered. Depends on tidtt_pkg (entry_t).
`default_nettype none

module tidtt_entry_ram #(
    parameter int DEPTH = tidtt_pkg::DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire tidtt_pkg::entry_t wdata,
    input  wire logic [AW-1:0]    raddr,
    output tidtt_pkg::entry_t     rdata
);

    tidtt_pkg::entry_t mem [DEPTH];
    tidtt_pkg::entry_t rdata_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one entry, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule : tidtt_entry_ram

`default_nettype wire

>>> design/tidtt_scan_unit.sv
// Shared compare unit: looks at one entry per cycle during a table scan.
// Tracks the match, the sorted insert point and the first ID gap.
// Depends on tidtt_pkg (entry_t, scan_flags_t).
`default_nettype none

module tidtt_scan_unit #(
    parameter int CW = 7
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       clear,
    input  wire logic                       cmp_valid,
    input  wire logic [CW-1:0]              cmp_idx,
    input  wire tidtt_pkg::entry_t          entry,
    input  wire logic [tidtt_pkg::ID_W-1:0] key,
    output tidtt_pkg::scan_flags_t          flags,
    output logic [CW-1:0]                   found_pos,
    output logic [CW-1:0]                   ins_pos,
    output logic [CW-1:0]                   gap_pos,
    output tidtt_pkg::entry_t               hit_entry
);

    tidtt_pkg::scan_flags_t flags_reg;
    tidtt_pkg::scan_flags_t flags_next;
    logic [CW-1:0]          found_pos_reg;
    logic [CW-1:0]          ins_pos_reg;
    logic [CW-1:0]          gap_pos_reg;
    tidtt_pkg::entry_t      hit_entry_reg;
    logic                   is_match;
    logic                   is_above;
    logic                   is_gap;

    // Compare the current entry against key and index
    assign is_match = (entry.out_id == key);
    assign is_above = (entry.out_id > key);
    assign is_gap   = (entry.out_id != tidtt_pkg::ID_W'(cmp_idx));

    // Latch the first occurrence of each condition
    always_comb
    begin
        flags_next = flags_reg;
        if (clear)
        begin
            flags_next = '0;
        end
        else if (cmp_valid)
        begin
            if (is_match)
            begin
                flags_next.found = 1'b1;
            end
            if (is_above)
            begin
                flags_next.ins_set = 1'b1;
            end
            if (is_gap)
            begin
                flags_next.gap_set = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    // Capture positions and the matched entry
    always_ff @(posedge clk)
    begin
        if (!clear && cmp_valid)
        begin
            if (is_match && !flags_reg.found)
            begin
                found_pos_reg <= cmp_idx;
                hit_entry_reg <= entry;
            end
            if (is_above && !flags_reg.ins_set)
            begin
                ins_pos_reg <= cmp_idx;
            end
            if (is_gap && !flags_reg.gap_set)
            begin
                gap_pos_reg <= cmp_idx;
            end
        end
    end

    assign flags     = flags_reg;
    assign found_pos = found_pos_reg;
    assign ins_pos   = ins_pos_reg;
    assign gap_pos   = gap_pos_reg;
    assign hit_entry = hit_entry_reg;

endmodule : tidtt_scan_unit

`default_nettype wire
